### src/trsc_pkg.sv
// Package for the register/stack CPU execute block.
// Holds opcodes, status codes, memory geometry and the structs shared by trsc_exec and the top level.
// No dependencies.
package trsc_pkg;

  localparam int unsigned NUM_REGS   = 6;
  localparam int unsigned REG_IDX_W  = 3;
  localparam logic [REG_IDX_W-1:0] SP_INDEX = 3'd4;

  localparam logic [63:0] MEM_BYTES  = 64'd65536;
  localparam int unsigned MEM_AW     = 16;
  localparam int unsigned NUM_BANKS  = 8;
  localparam int unsigned BANK_SEL_W = 3;
  localparam int unsigned BANK_AW    = MEM_AW - BANK_SEL_W;
  localparam int unsigned BANK_DEPTH = 1 << BANK_AW;

  localparam logic [7:0] OP_LOAD = 8'h10;
  localparam logic [7:0] OP_ADD  = 8'h20;
  localparam logic [7:0] OP_PUSH = 8'h30;
  localparam logic [7:0] OP_POP  = 8'h31;
  localparam logic [7:0] OP_END  = 8'hFF;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_END     = 3'd1,
    ST_BADREG  = 3'd2,
    ST_OVER    = 3'd3,
    ST_UNDER   = 3'd4,
    ST_UNKNOWN = 3'd5,
    ST_STOPPED = 3'd6
  } trsc_status_e;

  typedef struct packed {
    logic [63:0]          stack_pointer;
    logic [63:0]          dest_value;
    logic [REG_IDX_W-1:0] dest_index;
    logic                 reg_written;
    trsc_status_e         status;
  } trsc_result_t;

  typedef struct packed {
    logic                 dst_we;
    logic [REG_IDX_W-1:0] dst_idx;
    logic [63:0]          dst_val;
    logic                 sp_we;
    logic [63:0]          sp_val;
    logic                 mem_we;
    logic                 mem_re;
    logic [MEM_AW-1:0]    mem_addr;
    logic [63:0]          mem_wdata;
  } trsc_ctrl_t;

endpackage

### src/trsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module trsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/trsc_stack_mem.sv
// Byte-addressed data memory built from eight byte banks, so that an unaligned
// 8-byte little-endian word is written or read in one access. Uses trsc_pkg, trsc_ram.
module trsc_stack_mem
  import trsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [MEM_AW-1:0] addr_i,
  input  logic [63:0]       wdata_i,
  output logic [63:0]       rdata_o
);

  logic [7:0]            bank_rd [NUM_BANKS];
  logic [BANK_SEL_W-1:0] rd_ofs_q;

  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    localparam logic [BANK_SEL_W-1:0] K = BANK_SEL_W'(k);
    logic [BANK_SEL_W-1:0] byte_sel;
    logic [BANK_AW-1:0]    row;
    logic [7:0]            wbyte;

    // bank k holds byte (k - addr) mod 8 of the word; banks below the start wrap to next row
    always_comb begin
      byte_sel = K - addr_i[BANK_SEL_W-1:0];
      row      = addr_i[MEM_AW-1:BANK_SEL_W]
               + BANK_AW'(K < addr_i[BANK_SEL_W-1:0]);
      wbyte    = wdata_i[{byte_sel, 3'b000} +: 8];
    end

    trsc_ram #(
      .WIDTH(8),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (we_i),
      .waddr_i(row),
      .wdata_i(wbyte),
      .re_i   (re_i),
      .raddr_i(row),
      .rdata_o(bank_rd[k])
    );
  end

  // hold the start offset alongside the bank read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ofs_q <= '0;
    end else if (re_i) begin
      rd_ofs_q <= addr_i[BANK_SEL_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_BANKS; i++) begin
      rdata_o[8*i +: 8] = bank_rd[BANK_SEL_W'(rd_ofs_q + BANK_SEL_W'(i))];
    end
  end

endmodule

### src/trsc_exec.sv
// Instruction decode and execute for one word: status, register and stack updates.
// Pure combinational logic; uses trsc_pkg.
module trsc_exec
  import trsc_pkg::*;
(
  input  logic         stopped_i,
  input  logic [7:0]   mode_i,
  input  logic [7:0]   first_reg_i,
  input  logic [7:0]   second_reg_i,
  input  logic [63:0]  immediate_i,
  input  logic [63:0]  regs_i [NUM_REGS],
  input  logic [63:0]  mem_rdata_i,
  output trsc_result_t res_o,
  output trsc_ctrl_t   ctrl_o
);

  logic                 ra_ok;
  logic                 rb_ok;
  logic [REG_IDX_W-1:0] ra_idx;
  logic [63:0]          ra_val;
  logic [63:0]          rb_val;
  logic [63:0]          sp;
  logic [63:0]          sp_dec;
  logic [63:0]          sp_inc;
  logic                 push_over;
  logic                 pop_under;
  logic                 ra_is_sp;
  trsc_status_e         status;

  assign ra_ok     = first_reg_i < 8'(NUM_REGS);
  assign rb_ok     = second_reg_i < 8'(NUM_REGS);
  assign ra_idx    = first_reg_i[REG_IDX_W-1:0];
  assign ra_is_sp  = ra_idx == SP_INDEX;
  assign ra_val    = ra_ok ? regs_i[ra_idx] : '0;
  assign rb_val    = rb_ok ? regs_i[second_reg_i[REG_IDX_W-1:0]] : '0;
  assign sp        = regs_i[SP_INDEX];
  assign sp_dec    = sp - 64'd8;
  assign sp_inc    = sp + 64'd8;
  assign push_over = (sp < 64'd8) || (sp > MEM_BYTES);
  assign pop_under = sp > (MEM_BYTES - 64'd8);

  always_comb begin
    status           = ST_OK;
    ctrl_o           = '0;
    ctrl_o.mem_wdata = ra_is_sp ? sp_dec : ra_val;
    if (stopped_i) begin
      status = ST_STOPPED;
    end else begin
      case (mode_i)
        OP_LOAD: begin
          if (!ra_ok) begin
            status = ST_BADREG;
          end else begin
            ctrl_o.dst_we  = 1'b1;
            ctrl_o.dst_idx = ra_idx;
            ctrl_o.dst_val = immediate_i;
          end
        end
        OP_ADD: begin
          if (!ra_ok || !rb_ok) begin
            status = ST_BADREG;
          end else begin
            ctrl_o.dst_we  = 1'b1;
            ctrl_o.dst_idx = ra_idx;
            ctrl_o.dst_val = ra_val + rb_val;
          end
        end
        OP_PUSH: begin
          if (!ra_ok) begin
            status = ST_BADREG;
          end else if (push_over) begin
            status = ST_OVER;
          end else begin
            ctrl_o.sp_we    = 1'b1;
            ctrl_o.sp_val   = sp_dec;
            ctrl_o.mem_we   = 1'b1;
            ctrl_o.mem_addr = sp_dec[MEM_AW-1:0];
          end
        end
        OP_POP: begin
          if (!ra_ok) begin
            status = ST_BADREG;
          end else if (pop_under) begin
            status = ST_UNDER;
          end else begin
            ctrl_o.mem_re   = 1'b1;
            ctrl_o.mem_addr = sp[MEM_AW-1:0];
            ctrl_o.dst_we   = 1'b1;
            ctrl_o.dst_idx  = ra_idx;
            // popping into SP leaves the loaded value plus 8
            ctrl_o.dst_val  = ra_is_sp ? mem_rdata_i + 64'd8 : mem_rdata_i;
            ctrl_o.sp_we    = !ra_is_sp;
            ctrl_o.sp_val   = sp_inc;
          end
        end
        OP_END: begin
          status = ST_END;
        end
        default: begin
          status = ST_UNKNOWN;
        end
      endcase
    end
  end

  always_comb begin
    res_o        = '0;
    res_o.status = status;
    if (ctrl_o.dst_we) begin
      res_o.reg_written = 1'b1;
      res_o.dest_index  = ctrl_o.dst_idx;
      res_o.dest_value  = ctrl_o.dst_val;
    end else if (ctrl_o.sp_we) begin
      res_o.reg_written = 1'b1;
      res_o.dest_index  = SP_INDEX;
      res_o.dest_value  = ctrl_o.sp_val;
    end
    if (ctrl_o.dst_we && ctrl_o.dst_idx == SP_INDEX) begin
      res_o.stack_pointer = ctrl_o.dst_val;
    end else if (ctrl_o.sp_we) begin
      res_o.stack_pointer = ctrl_o.sp_val;
    end else begin
      res_o.stack_pointer = sp;
    end
  end

endmodule

### src/toy_register_stack_cpu_execute.sv
// Register/stack CPU execute stage: input register, execute logic, result register.
// An accepted word goes through the input register and the execute logic into the result
// register; a pop first issues its bank RAM read, then waits in the input register.
// Throughput: one word per cycle unless the output stalls or a pop waits on its read.
// Reset: registers zero, SP = MEM_BYTES, not stopped; data memory is not cleared.
// Uses trsc_pkg, trsc_exec, trsc_stack_mem.
module toy_register_stack_cpu_execute
  import trsc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [7:0] mode, [15:8] first_reg, [23:16] second_reg, [87:24] immediate
  input  logic [87:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [2:0] status, [3] reg_written, [6:4] dest_index, [70:7] dest_value,
  // [134:71] stack_pointer, [135] zero
  output logic [135:0] m_axis_tdata_o
);

  logic         s1_valid_q, s1_valid_d;
  logic [87:0]  s1_data_q;
  logic [63:0]  regs_q [NUM_REGS];
  logic [63:0]  regs_d [NUM_REGS];
  logic         stopped_q, stopped_d;
  logic         pop_phase_q, pop_phase_d;
  logic         m_valid_q, m_valid_d;
  trsc_result_t res_q;

  trsc_result_t ex_res;
  trsc_ctrl_t   ex_ctrl;
  logic [63:0]  mem_rdata;
  logic         out_free;
  logic         ex_wait;
  logic         fire;
  logic         in_acc;
  logic         mem_re;

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign ex_wait  = ex_ctrl.mem_re && !pop_phase_q;
  assign fire     = s1_valid_q && out_free && !ex_wait;
  assign mem_re   = s1_valid_q && ex_wait;

  assign s_axis_tready_o = !s1_valid_q || fire;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  trsc_exec u_exec (
    .stopped_i   (stopped_q),
    .mode_i      (s1_data_q[7:0]),
    .first_reg_i (s1_data_q[15:8]),
    .second_reg_i(s1_data_q[23:16]),
    .immediate_i (s1_data_q[87:24]),
    .regs_i      (regs_q),
    .mem_rdata_i (mem_rdata),
    .res_o       (ex_res),
    .ctrl_o      (ex_ctrl)
  );

  trsc_stack_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (fire && ex_ctrl.mem_we),
    .re_i   (mem_re),
    .addr_i (ex_ctrl.mem_addr),
    .wdata_i(ex_ctrl.mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    s1_valid_d = in_acc || (s1_valid_q && !fire);
    stopped_d  = stopped_q || (fire && ex_res.status != ST_OK);
    // advance to the data phase once the pop read is issued
    if (fire) begin
      pop_phase_d = 1'b0;
    end else if (mem_re) begin
      pop_phase_d = 1'b1;
    end else begin
      pop_phase_d = pop_phase_q;
    end
    if (fire) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
    for (int r = 0; r < NUM_REGS; r++) begin
      regs_d[r] = regs_q[r];
      if (fire && ex_ctrl.dst_we && ex_ctrl.dst_idx == REG_IDX_W'(r)) begin
        regs_d[r] = ex_ctrl.dst_val;
      end else if (fire && ex_ctrl.sp_we && SP_INDEX == REG_IDX_W'(r)) begin
        regs_d[r] = ex_ctrl.sp_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      stopped_q   <= 1'b0;
      pop_phase_q <= 1'b0;
      m_valid_q   <= 1'b0;
      for (int r = 0; r < NUM_REGS; r++) begin
        regs_q[r] <= (SP_INDEX == REG_IDX_W'(r)) ? MEM_BYTES : 64'd0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      stopped_q   <= stopped_d;
      pop_phase_q <= pop_phase_d;
      m_valid_q   <= m_valid_d;
      regs_q      <= regs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= s_axis_tdata_i;
    end
    if (fire) begin
      res_q <= ex_res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, res_q};

`ifndef SYNTHESIS
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("stopped flag cleared");

  a_fault_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && ex_res.status != ST_OK |-> !ex_ctrl.dst_we && !ex_ctrl.sp_we && !ex_ctrl.mem_we)
    else $error("faulting word updates state");

  a_phase_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_phase_q |-> s1_valid_q && ex_ctrl.mem_re)
    else $error("pop data phase without a pop in the input register");

  a_pop_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> s1_valid_q && pop_phase_q)
    else $error("pop read issued but word left the input register");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_axis_tready_i |-> !fire)
    else $error("result register overwritten while stalled");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for toy_register_stack_cpu_execute: random and directed instruction
// streams, checked word by word against an in-bench model of the register file and stack.
// Depends on trsc_pkg and the block RTL only.
`timescale 1ns / 100ps

module tb_top;
  import trsc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned STOPPED_ITEMS = 30;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PERCENT = 16;

  typedef struct packed {
    logic [63:0] immediate;
    logic [7:0]  second_reg;
    logic [7:0]  first_reg;
    logic [7:0]  mode;
  } cpu_instr_t;

  typedef enum int unsigned {
    FLT_END,
    FLT_UNKNOWN,
    FLT_BADREG,
    FLT_OVER,
    FLT_UNDER
  } fault_e;

  // Register file, stack bytes and halt flag, plus the results still owed by the block.
  class cpu_scoreboard;
    logic [63:0]  regs [NUM_REGS];
    logic [7:0]   stack_mem [bit [MEM_AW-1:0]];
    bit           halted;
    trsc_result_t pending_results [$];
    int unsigned  errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[SP_INDEX] = MEM_BYTES;
      halted = 1'b0;
      errors = 0;
    endfunction

    // True when a pop at the current SP is in bounds and reads only written bytes.
    function bit pop_is_defined();
      logic [63:0] top;
      top = regs[SP_INDEX];
      if (top > MEM_BYTES - 64'd8) return 1'b0;
      for (int i = 0; i < 8; i++) begin
        if (!stack_mem.exists(MEM_AW'(top + 64'(i)))) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void execute_instr(cpu_instr_t it);
      trsc_result_t res;
      logic [63:0]  top;
      logic [63:0]  val;
      res = '0;
      res.status = ST_OK;
      top = regs[SP_INDEX];
      if (halted) begin
        res.status = ST_STOPPED;
      end else begin
        case (it.mode)
          OP_LOAD: begin
            if (it.first_reg >= NUM_REGS) begin
              res.status = ST_BADREG;
            end else begin
              regs[it.first_reg] = it.immediate;
              res.reg_written = 1'b1;
              res.dest_index = it.first_reg[REG_IDX_W-1:0];
              res.dest_value = it.immediate;
            end
          end
          OP_ADD: begin
            if (it.first_reg >= NUM_REGS || it.second_reg >= NUM_REGS) begin
              res.status = ST_BADREG;
            end else begin
              regs[it.first_reg] = regs[it.first_reg] + regs[it.second_reg];
              res.reg_written = 1'b1;
              res.dest_index = it.first_reg[REG_IDX_W-1:0];
              res.dest_value = regs[it.first_reg];
            end
          end
          OP_PUSH: begin
            if (it.first_reg >= NUM_REGS) begin
              res.status = ST_BADREG;
            end else if (top < 64'd8 || top > MEM_BYTES) begin
              res.status = ST_OVER;
            end else begin
              // decrement first so a push of SP stores the new SP
              regs[SP_INDEX] = top - 64'd8;
              val = regs[it.first_reg];
              for (int i = 0; i < 8; i++) begin
                stack_mem[MEM_AW'(top - 64'd8 + 64'(i))] = val[8*i +: 8];
              end
              res.reg_written = 1'b1;
              res.dest_index = SP_INDEX;
              res.dest_value = top - 64'd8;
            end
          end
          OP_POP: begin
            if (it.first_reg >= NUM_REGS) begin
              res.status = ST_BADREG;
            end else if (top > MEM_BYTES - 64'd8) begin
              res.status = ST_UNDER;
            end else begin
              val = '0;
              for (int i = 0; i < 8; i++) begin
                if (stack_mem.exists(MEM_AW'(top + 64'(i))))
                  val[8*i +: 8] = stack_mem[MEM_AW'(top + 64'(i))];
              end
              regs[it.first_reg] = val;
              regs[SP_INDEX] = regs[SP_INDEX] + 64'd8;
              res.reg_written = 1'b1;
              res.dest_index = it.first_reg[REG_IDX_W-1:0];
              res.dest_value = regs[it.first_reg];
            end
          end
          OP_END:  res.status = ST_END;
          default: res.status = ST_UNKNOWN;
        endcase
      end
      if (res.status != ST_OK) halted = 1'b1;
      res.stack_pointer = regs[SP_INDEX];
      pending_results.push_back(res);
    endfunction

    function void check_result(trsc_result_t got);
      trsc_result_t exp;
      if (pending_results.size() == 0) begin
        $error("result word with no instruction outstanding: %h", got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.reg_written !== exp.reg_written) begin
        $error("reg_written: expected %0d, got %0d", exp.reg_written, got.reg_written);
        errors++;
      end
      if (got.dest_index !== exp.dest_index) begin
        $error("dest_index: expected %0d, got %0d", exp.dest_index, got.dest_index);
        errors++;
      end
      if (got.dest_value !== exp.dest_value) begin
        $error("dest_value: expected %h, got %h", exp.dest_value, got.dest_value);
        errors++;
      end
      if (got.stack_pointer !== exp.stack_pointer) begin
        $error("stack_pointer: expected %h, got %h", exp.stack_pointer, got.stack_pointer);
        errors++;
      end
    endfunction

    function void flush_check();
      if (pending_results.size() != 0) begin
        $error("%0d results never arrived", pending_results.size());
        errors++;
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  // [7:0] mode, [15:8] first_reg, [23:16] second_reg, [87:24] immediate
  logic [87:0]  s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  // [2:0] status, [3] reg_written, [6:4] dest_index, [70:7] dest_value,
  // [134:71] stack_pointer, [135] zero
  logic [135:0] m_axis_tdata_o;

  cpu_scoreboard sb;
  bit            quiet;
  int unsigned   cycle_count = 0;

  toy_register_stack_cpu_execute u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random back-pressure, none inside the quiet window.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(trsc_result_t'(m_axis_tdata_o[134:0]));
  end

  function automatic cpu_instr_t make_instr(logic [7:0] mode, logic [7:0] ra, logic [7:0] rb,
                                            logic [63:0] imm);
    cpu_instr_t it;
    it.mode = mode;
    it.first_reg = ra;
    it.second_reg = rb;
    it.immediate = imm;
    return it;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // SP values inside the push range, mostly near the top of memory.
  function automatic logic [63:0] rand_stack_top();
    case ($urandom_range(3))
      0, 1:    return MEM_BYTES - 64'(8 * $urandom_range(64));
      2:       return 64'($urandom_range(8, 65536));
      default: return 64'(8 * $urandom_range(1, 32));
    endcase
  endfunction

  // Draw a random instruction that neither faults nor pops unwritten bytes.
  function automatic cpu_instr_t pick_legal_instr();
    cpu_instr_t  it;
    logic [63:0] top;
    top = sb.regs[SP_INDEX];
    for (int t = 0; t < 16; t++) begin
      it = make_instr(OP_LOAD, 8'($urandom_range(NUM_REGS - 1)), 8'($urandom_range(255)),
                      rand_word());
      case ($urandom_range(3))
        0: begin
          if (it.first_reg == SP_INDEX) it.immediate = rand_stack_top();
          return it;
        end
        1: begin
          it.mode = OP_ADD;
          it.second_reg = 8'($urandom_range(NUM_REGS - 1));
          // rarely let an add scramble SP
          if (it.first_reg != SP_INDEX || $urandom_range(3) == 0) return it;
        end
        2: begin
          it.mode = OP_PUSH;
          if (top >= 64'd8 && top <= MEM_BYTES) return it;
        end
        default: begin
          it.mode = OP_POP;
          if (sb.pop_is_defined()) return it;
        end
      endcase
    end
    return make_instr(OP_LOAD, 8'(SP_INDEX), 8'($urandom_range(255)), rand_stack_top());
  endfunction

  task automatic send_instr(cpu_instr_t it);
    int unsigned gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PERCENT) gap++;
    end
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= it;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.execute_instr(it);
    @(negedge clk_i);
  endtask

  // Hold the input side until every owed result is out, then let the pipeline settle.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int          n;
    fault_e      fault_kind;
    logic [7:0]  op;
    cpu_instr_t  it;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    rst_ni = 1'b0;
    quiet = 1'b0;
    sb = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: value extremes, add wrap-around, push and pop at both stack ends,
    // push of SP and pop into SP.
    send_instr(make_instr(OP_LOAD, 8'd0, 8'd0, '0));
    send_instr(make_instr(OP_LOAD, 8'd1, 8'd255, '1));
    send_instr(make_instr(OP_LOAD, 8'd2, 8'd0, 64'h8000_0000_0000_0000));
    send_instr(make_instr(OP_ADD, 8'd2, 8'd2, '1));
    send_instr(make_instr(OP_ADD, 8'd1, 8'd0, '0));
    send_instr(make_instr(OP_ADD, 8'd3, 8'd1, '0));
    send_instr(make_instr(OP_LOAD, 8'd5, 8'd0, 64'd1));
    send_instr(make_instr(OP_ADD, 8'd1, 8'd5, '0));
    send_instr(make_instr(OP_PUSH, 8'd1, 8'd0, '1));
    send_instr(make_instr(OP_PUSH, 8'(SP_INDEX), 8'd0, '0));
    send_instr(make_instr(OP_PUSH, 8'd3, 8'd0, '0));
    send_instr(make_instr(OP_POP, 8'd5, 8'd0, '0));
    send_instr(make_instr(OP_POP, 8'(SP_INDEX), 8'd0, '0));
    send_instr(make_instr(OP_POP, 8'd0, 8'd0, '0));
    send_instr(make_instr(OP_LOAD, 8'(SP_INDEX), 8'd0, 64'd8));
    send_instr(make_instr(OP_PUSH, 8'd2, 8'd0, '0));
    send_instr(make_instr(OP_POP, 8'd3, 8'd0, '0));
    send_instr(make_instr(OP_ADD, 8'(SP_INDEX), 8'd3, '0));
    send_instr(make_instr(OP_LOAD, 8'(SP_INDEX), 8'd0, MEM_BYTES));
    drain_results();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 700 && n < 1000);
      if (n == 1200) drain_results();
      send_instr(pick_legal_instr());
    end
    quiet = 1'b0;
    drain_results();

    // One fault per run halts the block; the kind is drawn at random.
    fault_kind = fault_e'($urandom_range(4));
    case (fault_kind)
      FLT_END: begin
        send_instr(make_instr(OP_END, 8'($urandom_range(255)), 8'($urandom_range(255)),
                              rand_word()));
      end
      FLT_UNKNOWN: begin
        op = 8'($urandom_range(255));
        while (op inside {OP_LOAD, OP_ADD, OP_PUSH, OP_POP, OP_END}) op = 8'($urandom_range(255));
        send_instr(make_instr(op, 8'($urandom_range(5)), 8'($urandom_range(5)), rand_word()));
      end
      FLT_BADREG: begin
        case ($urandom_range(3))
          0:       op = OP_LOAD;
          1:       op = OP_ADD;
          2:       op = OP_PUSH;
          default: op = OP_POP;
        endcase
        it = make_instr(op, 8'($urandom_range(5)), 8'($urandom_range(5)), rand_word());
        if (op == OP_ADD && $urandom_range(1) == 0)
          it.second_reg = 8'($urandom_range(NUM_REGS, 255));
        else
          it.first_reg = 8'($urandom_range(NUM_REGS, 255));
        send_instr(it);
      end
      FLT_OVER: begin
        if ($urandom_range(1) == 0)
          send_instr(make_instr(OP_LOAD, 8'(SP_INDEX), 8'd0, 64'($urandom_range(7))));
        else
          send_instr(make_instr(OP_LOAD, 8'(SP_INDEX), 8'd0,
                                MEM_BYTES + 64'($urandom_range(1, 100000))));
        send_instr(make_instr(OP_PUSH, 8'($urandom_range(5)), 8'd0, rand_word()));
      end
      default: begin
        if ($urandom_range(1) == 0)
          send_instr(make_instr(OP_LOAD, 8'(SP_INDEX), 8'd0,
                                MEM_BYTES - 64'($urandom_range(7))));
        else
          send_instr(make_instr(OP_LOAD, 8'(SP_INDEX), 8'd0, {1'b1, 63'($urandom)}));
        send_instr(make_instr(OP_POP, 8'($urandom_range(5)), 8'd0, rand_word()));
      end
    endcase

    // Halted: any field values at all, each must come back as stopped.
    for (n = 0; n < STOPPED_ITEMS; n++) begin
      send_instr(make_instr(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), rand_word()));
    end
    drain_results();
    repeat (10) @(posedge clk_i);
    sb.flush_check();
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### sim.f
src/trsc_pkg.sv
src/trsc_ram.sv
src/trsc_stack_mem.sv
src/trsc_exec.sv
src/toy_register_stack_cpu_execute.sv
tb/tb_top.sv
